// ----- design/rms_pkg.sv -----
// shared types and constants of the running median filter
package rms_pkg;

  localparam int unsigned MAX_WINDOW = 15;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_WINDOW);

  localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(5);
  localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MAX_WINDOW);

  typedef logic signed [DATA_W-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_PRELOAD_VALUE = 1'b1
  } reg_idx_t;

  // request kinds carried on the input tuser
  typedef enum logic [0:0] {
    REQ_SAMPLE  = 1'b0,
    REQ_RESTART = 1'b1
  } req_t;

  // one control word broadcast to every cell
  typedef struct packed {
    logic fill;    // load preload into both stores
    logic remove;  // take the outgoing value out, shift arrival line
    logic insert;  // put the new value in order
  } cell_ctl_t;

endpackage

// ----- design/running_median_signed.sv -----
// sliding-window median filter over signed 32-bit samples
// a sample word is removed from the window on acceptance, inserted, then emitted on out_tdata;
// a restart refills and then emits; no new word is taken until emit is done; removal and
//   insertion each take one pass through the chain of sorted cells, then the middle cell
//   is registered out, and a held-back result stretches the emit step while out_tready is low
// reset (rst_n low, synchronous): length 5, preload 0, all cells loaded with 0, control cleared
module running_median_signed (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // [31:0] sample
  input  logic [0:0]             in_tuser,   // [0] req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,  // [31:0] median
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data
);
  import rms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INS  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  sample_t          preload_r, preload_nxt;
  sample_t          x_r;
  logic             out_valid_r, out_valid_nxt;
  sample_t          out_data_r;

  sample_t          s_q   [MAX_WINDOW];
  sample_t          arr_q [MAX_WINDOW];
  logic             gt_q  [MAX_WINDOW];

  logic             in_acc, cfg_acc, len_ok, out_free;
  logic [LEN_W-1:0] top_idx, mid_idx;
  sample_t          old_val;
  sample_t          fill_val;
  cell_ctl_t        ctl;

  assign in_acc   = in_tvalid && in_tready;
  assign cfg_acc  = cfg_valid && cfg_ready;
  // a pending register write goes first, so a word and a write never land together
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // odd nonzero lengths up to the cell count only
  assign len_ok   = cfg_data[0] && (cfg_data[LEN_W-1:0] <= MAX_LEN);

  assign top_idx  = len_r - LEN_W'(1);
  assign mid_idx  = len_r >> 1;
  assign old_val  = arr_q[top_idx[IDX_W-1:0]];
  assign fill_val = rst_n ? preload_r : '0;

  always_comb begin
    ctl        = '0;
    ctl.fill   = !rst_n
              || (in_acc && (in_tuser[0] == REQ_RESTART))
              || (cfg_acc && (cfg_index == REG_WINDOW_LENGTH) && len_ok);
    ctl.remove = rst_n && in_acc && (in_tuser[0] == REQ_SAMPLE);
    ctl.insert = rst_n && (state_r == ST_INS);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      rms_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .last      (top_idx == LEN_W'(gi)),
        .preload   (fill_val),
        .old_val   (old_val),
        .new_val   ((state_r == ST_INS) ? x_r : sample_t'(in_tdata)),
        .s_above   (s_q[(gi == MAX_WINDOW - 1) ? gi : gi + 1]),
        .s_below   (s_q[(gi == 0) ? 0 : gi - 1]),
        .gt_below  ((gi == 0) ? 1'b0 : gt_q[(gi == 0) ? 0 : gi - 1]),
        .arr_below ((gi == 0) ? sample_t'(in_tdata) : arr_q[(gi == 0) ? 0 : gi - 1]),
        .s_q       (s_q[gi]),
        .arr_q     (arr_q[gi]),
        .gt_q      (gt_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    preload_nxt   = preload_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_acc) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: if (len_ok) len_nxt = cfg_data[LEN_W-1:0];
        REG_PRELOAD_VALUE: preload_nxt = sample_t'(cfg_data);
        default: ;
      endcase
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser[0] == REQ_RESTART) ? ST_EMIT : ST_INS;
        end
      end
      ST_INS:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_RESET;
      preload_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      preload_r   <= preload_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= sample_t'(in_tdata);
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_data_r <= s_q[mid_idx[IDX_W-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a sample goes through removal and insertion before it is emitted
  a_sample_to_ins: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == REQ_SAMPLE)) |=> (state_r == ST_INS))
    else $error("sample did not enter the insert pass");

  a_ins_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=> (state_r == ST_EMIT))
    else $error("insert pass not followed by emit");

  // an accepted length change reloads the sorted chain with the preload value
  a_len_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_acc && (cfg_index == REG_WINDOW_LENGTH) && len_ok)
      |=> (s_q[0] == $past(preload_r)) && (len_r == $past(cfg_data[LEN_W-1:0])))
    else $error("length change did not refill the window");

  // the bottom of the sorted chain stays in order between items
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (len_r > LEN_W'(1))) |-> (s_q[0] <= s_q[1]))
    else $error("sorted chain out of order");

endmodule

// ----- design/rms_cell.sv -----
// one cell of the sorted chain: a sorted slot and an arrival slot
module rms_cell (
  input  logic              clk,
  input  rms_pkg::cell_ctl_t ctl,
  input  logic              last,      // this cell is the top of the window
  input  rms_pkg::sample_t  preload,
  input  rms_pkg::sample_t  old_val,   // value leaving the window
  input  rms_pkg::sample_t  new_val,   // value entering the window
  input  rms_pkg::sample_t  s_above,   // sorted slot of the next cell up
  input  rms_pkg::sample_t  s_below,   // sorted slot of the next cell down
  input  logic              gt_below,  // next cell down is at or past the insert point
  input  rms_pkg::sample_t  arr_below, // arrival slot of the next cell down
  output rms_pkg::sample_t  s_q,
  output rms_pkg::sample_t  arr_q,
  output logic              gt_q
);
  import rms_pkg::*;

  sample_t s_r, s_nxt;
  sample_t arr_r, arr_nxt;
  logic    at_or_past_old;

  // sorted copy holds the outgoing value at the first slot where this turns true
  assign at_or_past_old = (s_r >= old_val);
  assign gt_q           = last || (s_r > new_val);

  always_comb begin
    s_nxt   = s_r;
    arr_nxt = arr_r;
    if (ctl.fill) begin
      s_nxt   = preload;
      arr_nxt = preload;
    end else if (ctl.remove) begin
      arr_nxt = arr_below;
      if (at_or_past_old) begin
        s_nxt = s_above;
      end
    end else if (ctl.insert) begin
      if (gt_q) begin
        s_nxt = gt_below ? s_below : new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    arr_r <= arr_nxt;
  end

  assign s_q   = s_r;
  assign arr_q = arr_r;

endmodule
